FILE: sv/sap_pkg.sv
package sap_pkg;

    // active list geometry
    localparam int ACTIVE_DEPTH = 32;
    localparam int IDX_W        = $clog2(ACTIVE_DEPTH);
    localparam int CNT_W        = $clog2(ACTIVE_DEPTH + 1);

    // word fields
    localparam int COORD_BITS = 32;
    localparam int ID_W       = 10;
    localparam int AXIS_W     = 2;

    // input queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // register port
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    // sweep axis codes
    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    // register index, taken from paddr[2]
    localparam logic REG_SWEEP_AXIS = 1'b0;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [ID_W-1:0] obj_id_t;

    typedef struct packed {
        obj_id_t id;
        coord_t  min_x;
        coord_t  min_y;
        coord_t  min_z;
        coord_t  max_x;
        coord_t  max_y;
        coord_t  max_z;
    } entry_t;

    typedef struct packed {
        logic              frame_start;
        logic [AXIS_W-1:0] axis;
        coord_t            sweep_min;
        entry_t            ent;
    } cmd_t;

    typedef struct packed {
        obj_id_t earlier_id;
        obj_id_t current_id;
        logic    last_pair;
        logic    boxes_dropped;
    } result_t;

endpackage

FILE: sv/sap_front.sv
module sap_front import sap_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic              frame_start,
    input  obj_id_t           object_id,
    input  coord_t            min_x,
    input  coord_t            min_y,
    input  coord_t            min_z,
    input  coord_t            max_x,
    input  coord_t            max_y,
    input  coord_t            max_z,
    input  logic [AXIS_W-1:0] sweep_axis,
    output logic              cmd_valid,
    output cmd_t              cmd,
    input  logic              cmd_take
);

    cmd_t              q_reg [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    cmd_t              new_cmd;
    logic              do_push;
    logic              do_pop;

    // classify: pick sweep key, fold the unused axis code onto x
    always_comb
    begin
        new_cmd.frame_start = frame_start;
        new_cmd.ent.id      = object_id;
        new_cmd.ent.min_x   = min_x;
        new_cmd.ent.min_y   = min_y;
        new_cmd.ent.min_z   = min_z;
        new_cmd.ent.max_x   = max_x;
        new_cmd.ent.max_y   = max_y;
        new_cmd.ent.max_z   = max_z;
        case (sweep_axis)
            AXIS_Y:
            begin
                new_cmd.axis      = AXIS_Y;
                new_cmd.sweep_min = min_y;
            end
            AXIS_Z:
            begin
                new_cmd.axis      = AXIS_Z;
                new_cmd.sweep_min = min_z;
            end
            default:
            begin
                new_cmd.axis      = AXIS_X;
                new_cmd.sweep_min = min_x;
            end
        endcase
    end

    assign full      = (cnt_reg == QCNT_W'(Q_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

FILE: sv/sap_back.sv
module sap_back import sap_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    input  cmd_t    cmd,
    output logic    cmd_take,
    output logic    res_push,
    output result_t res,
    input  logic    res_full
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_WALK   = 4'b0010,
        ST_APPEND = 4'b0100,
        ST_DRAIN  = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    cmd_t             cur_reg, cur_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             drop_reg, drop_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] r_reg, r_next;
    logic [CNT_W-1:0] w_reg, w_next;
    logic [CNT_W-1:0] hits_reg, hits_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             rvalid_reg, rvalid_next;

    entry_t           act_mem [ACTIVE_DEPTH];
    entry_t           rd_entry_reg;
    obj_id_t          hit_ids_reg [ACTIVE_DEPTH];

    coord_t           emax;
    logic             survive;
    logic             overlap;
    logic             walk_keep;
    logic             walk_hit;
    logic             has_room;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    entry_t           mem_wd;
    logic [CNT_W-1:0] k_plus;

    // prune and overlap test on the entry read last cycle
    always_comb
    begin
        case (cur_reg.axis)
            AXIS_Y:  emax = rd_entry_reg.max_y;
            AXIS_Z:  emax = rd_entry_reg.max_z;
            default: emax = rd_entry_reg.max_x;
        endcase
        survive = (cur_reg.sweep_min <= emax);
        overlap = (cur_reg.ent.min_x <= rd_entry_reg.max_x) &&
                  (rd_entry_reg.min_x <= cur_reg.ent.max_x) &&
                  (cur_reg.ent.min_y <= rd_entry_reg.max_y) &&
                  (rd_entry_reg.min_y <= cur_reg.ent.max_y) &&
                  (cur_reg.ent.min_z <= rd_entry_reg.max_z) &&
                  (rd_entry_reg.min_z <= cur_reg.ent.max_z);
    end

    assign walk_keep = (state_reg == ST_WALK) && rvalid_reg && survive;
    assign walk_hit  = walk_keep && overlap;
    assign has_room  = (w_reg < CNT_W'(ACTIVE_DEPTH));
    assign mem_we    = walk_keep || ((state_reg == ST_APPEND) && has_room);
    assign mem_wa    = w_reg[IDX_W-1:0];
    assign mem_wd    = (state_reg == ST_WALK) ? rd_entry_reg : cur_reg.ent;

    assign k_plus             = k_reg + CNT_W'(1);
    assign res.earlier_id     = hit_ids_reg[k_reg[IDX_W-1:0]];
    assign res.current_id     = cur_reg.ent.id;
    assign res.last_pair      = (k_plus == hits_reg);
    assign res.boxes_dropped  = drop_reg;
    assign res_push           = (state_reg == ST_DRAIN) && !res_full;
    assign cmd_take           = (state_reg == ST_IDLE) && cmd_valid;

    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        count_next  = count_reg;
        drop_next   = drop_reg;
        n_next      = n_reg;
        r_next      = r_reg;
        w_next      = w_reg;
        hits_next   = hits_reg;
        k_next      = k_reg;
        rvalid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cur_next  = cmd;
                    n_next    = cmd.frame_start ? '0 : count_reg;
                    if (cmd.frame_start)
                    begin
                        drop_next = 1'b0;
                    end
                    r_next     = '0;
                    w_next     = '0;
                    hits_next  = '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                // one read issued per cycle, compaction write trails it
                if (r_reg < n_reg)
                begin
                    r_next      = r_reg + CNT_W'(1);
                    rvalid_next = 1'b1;
                end
                if (walk_keep)
                begin
                    w_next = w_reg + CNT_W'(1);
                end
                if (walk_hit)
                begin
                    hits_next = hits_reg + CNT_W'(1);
                end
                if ((r_reg == n_reg) && !rvalid_reg)
                begin
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND:
            begin
                if (has_room)
                begin
                    count_next = w_reg + CNT_W'(1);
                end
                else
                begin
                    count_next = w_reg;
                    drop_next  = 1'b1;
                end
                k_next     = '0;
                state_next = (hits_reg == '0) ? ST_IDLE : ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!res_full)
                begin
                    k_next = k_plus;
                    if (k_plus == hits_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            drop_reg   <= 1'b0;
            n_reg      <= '0;
            r_reg      <= '0;
            w_reg      <= '0;
            hits_reg   <= '0;
            k_reg      <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            drop_reg   <= drop_next;
            n_reg      <= n_next;
            r_reg      <= r_next;
            w_reg      <= w_next;
            hits_reg   <= hits_next;
            k_reg      <= k_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    // active list memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            act_mem[mem_wa] <= mem_wd;
        end
        rd_entry_reg <= act_mem[r_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (walk_hit)
        begin
            hit_ids_reg[hits_reg[IDX_W-1:0]] <= rd_entry_reg.id;
        end
    end

endmodule

FILE: sv/sap_outq.sv
module sap_outq import sap_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    res_push,
    input  result_t res,
    output logic    res_full,
    input  logic    pop,
    output logic    empty,
    output result_t dout
);

    result_t           q_reg [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign res_full = (cnt_reg == QCNT_W'(Q_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign dout     = q_reg[rd_ptr_reg];
    assign do_push  = res_push && !res_full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= res;
        end
    end

endmodule

FILE: sv/sweep_and_prune_broadphase_core.sv
// flow: a box is taken from the input queue while the back end is idle, walks the n live
// entries of the active list through a registered read port, is appended to the list, then
// drains its pairs one word per cycle while the result queue has room
// the next box is taken only after the previous one is through, so the pace is set by
// the single read port of the active list memory and the one-word-per-cycle pair drain
// reset: clears queues, active count, drop flag and sweep axis; list memory keeps contents
module sweep_and_prune_broadphase_core import sap_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    // box words in
    input  logic              push,
    output logic              full,
    input  logic              frame_start,
    input  obj_id_t           object_id,
    input  coord_t            min_x,
    input  coord_t            min_y,
    input  coord_t            min_z,
    input  coord_t            max_x,
    input  coord_t            max_y,
    input  coord_t            max_z,
    // pair words out
    output logic              empty,
    input  logic              pop,
    output obj_id_t           earlier_id,
    output obj_id_t           current_id,
    output logic              last_pair,
    output logic              boxes_dropped
);

    logic [AXIS_W-1:0] axis_reg, axis_next;
    logic              cfg_wr;
    logic              cmd_valid;
    cmd_t              cmd;
    logic              cmd_take;
    logic              res_push;
    result_t           res;
    logic              res_full;
    result_t           dout;

    // register port: zero wait states, only the sweep axis register exists
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SWEEP_AXIS);

    always_comb
    begin
        axis_next = cfg_wr ? pwdata[AXIS_W-1:0] : axis_reg;
    end

    always_comb
    begin
        case (paddr[2])
            REG_SWEEP_AXIS: prdata = {{(DATA_W-AXIS_W){1'b0}}, axis_reg};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg <= AXIS_X;
        end
        else
        begin
            axis_reg <= axis_next;
        end
    end

    // front: input queue, picks the sweep key per box
    sap_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .frame_start (frame_start),
        .object_id   (object_id),
        .min_x       (min_x),
        .min_y       (min_y),
        .min_z       (min_z),
        .max_x       (max_x),
        .max_y       (max_y),
        .max_z       (max_z),
        .sweep_axis  (axis_reg),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_take    (cmd_take)
    );

    // back: prune, compact, overlap test, append, drain pairs
    sap_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .res_push  (res_push),
        .res       (res),
        .res_full  (res_full)
    );

    // result queue decouples the drain from the consumer
    sap_outq u_outq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res      (res),
        .res_full (res_full),
        .pop      (pop),
        .empty    (empty),
        .dout     (dout)
    );

    assign earlier_id    = dout.earlier_id;
    assign current_id    = dout.current_id;
    assign last_pair     = dout.last_pair;
    assign boxes_dropped = dout.boxes_dropped;

endmodule

FILE: sv/sap_checker.sv
module sap_checker import sap_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [ADDR_W-1:0] paddr,
    input logic [DATA_W-1:0] pwdata,
    input logic [DATA_W-1:0] prdata,
    input logic              pready,
    input logic              empty,
    input logic              pop,
    input obj_id_t           earlier_id,
    input obj_id_t           current_id,
    input logic              last_pair,
    input logic              boxes_dropped
);

    // a waiting pair word holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(earlier_id) && $stable(current_id) &&
                              $stable(last_pair) && $stable(boxes_dropped)))
        else $error("pair word changed while waiting");

    // words of one box share the current id
    a_same_box: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !last_pair) |=>
            (empty || (current_id == $past(current_id))))
        else $error("pair words of one box split");

    // the drop flag is the same on every word of one box
    a_drop_const: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !last_pair) |=>
            (empty || (boxes_dropped == $past(boxes_dropped))))
        else $error("drop flag changed within one box");

    // a sweep axis write reads back
    a_axis_rb: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && (paddr[2] == REG_SWEEP_AXIS)) |=>
            ((paddr[2] != REG_SWEEP_AXIS) ||
             (prdata == {{(DATA_W-AXIS_W){1'b0}}, $past(pwdata[AXIS_W-1:0])})))
        else $error("sweep axis readback mismatch");

endmodule

bind sweep_and_prune_broadphase_core sap_checker u_sap_checker (.*);

FILE: sim/tb.sv
module tb;
    import sap_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // axis code three has no name in the package; the block sweeps on x for it
    localparam logic [AXIS_W-1:0] AXIS_ALT_X = 2'd3;

    // one q16.16 unit
    localparam int UNIT = 65536;

    // coordinate extremes
    localparam coord_t C_MIN = 32'sh8000_0000;
    localparam coord_t C_MAX = 32'sh7fff_ffff;

    // cycles to let the block finish boxes that cause no pair word: up to three boxes
    // may still be in flight, in the input queue and the back end
    localparam int SETTLE_CYCLES = 250;

    // receiver hold-off used to back the block up
    localparam int HOLD_CYCLES = 400;

    // cycles with no word accepted before the run is declared hung; the longest
    // quiet stretch in a good run is the hold-off or a settle plus one box walk
    localparam int QUIET_LIMIT = 4000;

    typedef struct {
        logic    frame_start;
        obj_id_t object_id;
        coord_t  min_x;
        coord_t  min_y;
        coord_t  min_z;
        coord_t  max_x;
        coord_t  max_y;
        coord_t  max_z;
    } box_t;

    // clock, reset and block ports, all known from time zero
    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              push = 1'b0;
    logic              full;
    logic              frame_start = 1'b0;
    obj_id_t           object_id = '0;
    coord_t            min_x = '0;
    coord_t            min_y = '0;
    coord_t            min_z = '0;
    coord_t            max_x = '0;
    coord_t            max_y = '0;
    coord_t            max_z = '0;
    logic              empty;
    logic              pop = 1'b0;
    obj_id_t           earlier_id;
    obj_id_t           current_id;
    logic              last_pair;
    logic              boxes_dropped;

    // box words waiting to be offered, and pair words still owed by the block
    box_t    boxes_waiting [$];
    result_t pairs_due [$];

    // the word currently on the input ports
    box_t offered;
    logic offering = 1'b0;

    // shadow of the active list and the sweep axis register
    box_t              live_box [ACTIVE_DEPTH];
    int                live_cnt = 0;
    logic              drop_seen = 1'b0;
    logic [AXIS_W-1:0] cur_axis = AXIS_X;

    // traffic shaping
    int   send_idle = 0;
    int   recv_idle = 0;
    logic hold_on = 1'b0;
    int   hold_left = 0;

    // bookkeeping
    int boxes_sent = 0;
    int pairs_seen = 0;
    int boxes_lost = 0;
    int mismatches = 0;
    int quiet = 0;

    sweep_and_prune_broadphase_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .push          (push),
        .full          (full),
        .frame_start   (frame_start),
        .object_id     (object_id),
        .min_x         (min_x),
        .min_y         (min_y),
        .min_z         (min_z),
        .max_x         (max_x),
        .max_y         (max_y),
        .max_z         (max_z),
        .empty         (empty),
        .pop           (pop),
        .earlier_id    (earlier_id),
        .current_id    (current_id),
        .last_pair     (last_pair),
        .boxes_dropped (boxes_dropped)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // sweep one accepted box through the shadow list and queue the pair words it owes
    task automatic sweep_box(input box_t b);
        obj_id_t hit_ids [$];
        coord_t  new_min;
        coord_t  ent_max;
        box_t    e;
        result_t pr;
        int      r;
        int      k;
        int      keep;
        keep = 0;
        if (b.frame_start)
        begin
            live_cnt = 0;
            drop_seen = 1'b0;
        end
        // axis code three falls through to x
        new_min = (cur_axis == AXIS_Y) ? b.min_y : (cur_axis == AXIS_Z) ? b.min_z : b.min_x;
        for (r = 0; r < live_cnt; r++)
        begin
            e = live_box[r];
            ent_max = (cur_axis == AXIS_Y) ? e.max_y : (cur_axis == AXIS_Z) ? e.max_z : e.max_x;
            // strictly below the new minimum: pruned, a tie survives
            if (new_min > ent_max)
                continue;
            // inclusive overlap on all three axes, inverted boxes taken as given
            if (b.min_x <= e.max_x && e.min_x <= b.max_x &&
                b.min_y <= e.max_y && e.min_y <= b.max_y &&
                b.min_z <= e.max_z && e.min_z <= b.max_z)
                hit_ids.insert(hit_ids.size(), e.object_id);
            live_box[keep] = e;
            keep++;
        end
        // a full list still reports pairs, but the box itself is lost
        if (keep < ACTIVE_DEPTH)
        begin
            live_box[keep] = b;
            keep++;
        end
        else
        begin
            drop_seen = 1'b1;
            boxes_lost++;
        end
        live_cnt = keep;
        for (k = 0; k < hit_ids.size(); k++)
        begin
            pr.earlier_id = hit_ids[k];
            pr.current_id = b.object_id;
            pr.last_pair = (k == hit_ids.size() - 1);
            pr.boxes_dropped = drop_seen;
            pairs_due.insert(pairs_due.size(), pr);
        end
    endtask

    // box word driver: holds a word until taken, then may idle before the next
    always @(posedge clk)
    begin : box_driver
        box_t nxt;
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                sweep_box(offered);
                boxes_sent++;
            end
            if (!(push && full))
            begin
                if (boxes_waiting.size() != 0 && $urandom_range(0, 99) >= send_idle)
                begin
                    nxt = boxes_waiting.pop_front();
                    offered = nxt;
                    offering = 1'b1;
                    push <= 1'b1;
                    frame_start <= nxt.frame_start;
                    object_id <= nxt.object_id;
                    min_x <= nxt.min_x;
                    min_y <= nxt.min_y;
                    min_z <= nxt.min_z;
                    max_x <= nxt.max_x;
                    max_y <= nxt.max_y;
                    max_z <= nxt.max_z;
                end
                else
                begin
                    offering = 1'b0;
                    push <= 1'b0;
                end
            end
        end
    end

    // pair word monitor: checks each popped word against the oldest one owed
    always @(posedge clk)
    begin : pair_monitor
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                got.earlier_id = earlier_id;
                got.current_id = current_id;
                got.last_pair = last_pair;
                got.boxes_dropped = boxes_dropped;
                pairs_seen++;
                if (pairs_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"pair word with none owed: ",
                                  "earlier %0d current %0d last %0b dropped %0b"},
                                 got.earlier_id, got.current_id, got.last_pair,
                                 got.boxes_dropped);
                end
                else
                begin
                    want = pairs_due.pop_front();
                    if (got.earlier_id !== want.earlier_id || got.current_id !== want.current_id ||
                        got.last_pair !== want.last_pair ||
                        got.boxes_dropped !== want.boxes_dropped)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"pair word %0d: want %0d/%0d last %0b drop %0b, ",
                                      "got %0d/%0d last %0b drop %0b"},
                                     pairs_seen, want.earlier_id, want.current_id,
                                     want.last_pair, want.boxes_dropped, got.earlier_id,
                                     got.current_id, got.last_pair, got.boxes_dropped);
                    end
                end
            end
            // a requested hold-off is counted out here, one cycle at a time
            if (hold_on)
            begin
                hold_left = HOLD_CYCLES;
                hold_on = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    // hang detector: counts cycles in which no word moves on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("no word moved for %0d cycles, %0d pair words still owed",
                         quiet, pairs_due.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    // register write with a read-back, only issued while the block is idle
    task automatic set_axis(input logic [AXIS_W-1:0] ax);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_SWEEP_AXIS, 2'b00};
        pwdata <= DATA_W'(ax);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        cur_axis = ax;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== DATA_W'(ax))
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("sweep axis read back %0h, wrote %0h", prdata, ax);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // wait until every box is taken and every pair word has come, then linger
    task automatic wait_idle(input int extra);
        while (boxes_waiting.size() != 0 || offering || pairs_due.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic queue_box(input logic fs, input obj_id_t id,
                             input coord_t x0, input coord_t y0, input coord_t z0,
                             input coord_t x1, input coord_t y1, input coord_t z1);
        box_t b;
        b.frame_start = fs;
        b.object_id = id;
        b.min_x = x0;
        b.min_y = y0;
        b.min_z = z0;
        b.max_x = x1;
        b.max_y = y1;
        b.max_z = z1;
        boxes_waiting.insert(boxes_waiting.size(), b);
    endtask

    // three boxes whose pairs depend on the sweep axis: on x the first box is
    // pruned before the unsorted third one arrives, on y and z it is not
    task automatic queue_axis_probe();
        queue_box(1'b1, obj_id_t'($urandom()), 0, 0, 0, 10 * UNIT, 100 * UNIT, 100 * UNIT);
        queue_box(1'b0, obj_id_t'($urandom()), 20 * UNIT, 0, 0,
                  30 * UNIT, 100 * UNIT, 100 * UNIT);
        queue_box(1'b0, obj_id_t'($urandom()), 5 * UNIT, 0, 0,
                  30 * UNIT, 100 * UNIT, 100 * UNIT);
    endtask

    // a frame sorted on the sweep axis; crowded frames keep the boxes that are not inverted
    // alive and overlapping, so the list fills up and later boxes are dropped
    task automatic queue_sorted(input int count, input logic crowded);
        box_t   b;
        coord_t base [3];
        coord_t lo [3];
        coord_t hi [3];
        int     unit;
        int     sax;
        int     ax;
        int     i;
        unit = 1 << (8 * $urandom_range(0, 2));
        sax = (cur_axis == AXIS_Y) ? 1 : (cur_axis == AXIS_Z) ? 2 : 0;
        for (ax = 0; ax < 3; ax++)
            base[ax] = coord_t'($signed($urandom()) >>> 1);
        for (i = 0; i < count; i++)
        begin
            for (ax = 0; ax < 3; ax++)
            begin
                if (ax == sax)
                begin
                    base[ax] = base[ax] + coord_t'($urandom_range(0, 3) * unit);
                    lo[ax] = base[ax];
                end
                else
                begin
                    lo[ax] = base[ax] + coord_t'($urandom_range(0, crowded ? 2 : 12) * unit);
                end
                hi[ax] = lo[ax] + coord_t'($urandom_range(0, 6) * unit);
                if (crowded)
                    hi[ax] = hi[ax] + coord_t'(200 * unit);
                // now and then an inverted side, min above max
                if ($urandom_range(0, 15) == 0)
                    hi[ax] = lo[ax] - coord_t'($urandom_range(1, 4) * unit);
            end
            b.frame_start = (i == 0);
            b.object_id = obj_id_t'($urandom());
            b.min_x = lo[0];
            b.min_y = lo[1];
            b.min_z = lo[2];
            b.max_x = hi[0];
            b.max_y = hi[1];
            b.max_z = hi[2];
            boxes_waiting.insert(boxes_waiting.size(), b);
        end
    endtask

    // unsorted boxes with arbitrary corners and frame marks
    task automatic queue_noise(input int count);
        int i;
        for (i = 0; i < count; i++)
            queue_box(1'($urandom_range(0, 1)), obj_id_t'($urandom()),
                      coord_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()),
                      coord_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()));
    endtask

    // mostly well-formed frames, some short ones, a few crowded, the rest noise
    task automatic queue_random(input int n);
        int made;
        int cnt;
        int pick;
        made = 0;
        while (made < n)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 6)
                cnt = $urandom_range(33, 38);
            else if (pick == 7)
                cnt = $urandom_range(2, 6);
            else if (pick >= 8)
                cnt = $urandom_range(1, 5);
            else
                cnt = $urandom_range(2, 16);
            if (pick >= 8)
                queue_noise(cnt);
            else
                queue_sorted(cnt, pick == 6);
            made += cnt;
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles often, receiver more often
        send_idle = 37;
        recv_idle = 73;

        // corners of the coordinate range, on the reset axis (x)
        queue_box(1'b1, 10'd0, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
        queue_box(1'b0, 10'h3ff, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
        queue_box(1'b0, 10'h155, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN);
        // touching boxes: shared faces overlap, a tie on the sweep axis survives
        queue_box(1'b1, 10'h2aa, 0, 0, 0, 100 * UNIT, 100 * UNIT, 100 * UNIT);
        queue_box(1'b0, 10'h001, 100 * UNIT, 100 * UNIT, 100 * UNIT,
                  200 * UNIT, 200 * UNIT, 200 * UNIT);
        // first box pruned one unit past its max
        queue_box(1'b0, 10'h200, 101 * UNIT, 50 * UNIT, 50 * UNIT,
                  160 * UNIT, 150 * UNIT, 150 * UNIT);
        // inverted on x, compared as given
        queue_box(1'b0, 10'h07f, 150 * UNIT, 0, 0, 120 * UNIT, 300 * UNIT, 300 * UNIT);
        // no overlap at all: no pair word
        queue_box(1'b0, 10'h380, 150 * UNIT, 1000 * UNIT, 0,
                  400 * UNIT, 1100 * UNIT, 300 * UNIT);
        queue_axis_probe();
        wait_idle(SETTLE_CYCLES);

        // axis code three behaves as x
        set_axis(AXIS_ALT_X);
        queue_axis_probe();
        wait_idle(SETTLE_CYCLES);

        set_axis(AXIS_Y);
        queue_axis_probe();
        queue_random(135);
        wait_idle(SETTLE_CYCLES);

        // swap the idling of the two sides
        send_idle = 73;
        recv_idle = 37;
        set_axis(AXIS_Z);
        queue_axis_probe();
        // receiver holds off while a crowded frame keeps coming, backing up the block
        hold_on = 1'b1;
        queue_sorted(36, 1'b1);
        wait_idle(SETTLE_CYCLES);
        queue_random(100);
        wait_idle(SETTLE_CYCLES);

        // full speed on both sides, back to x
        send_idle = 0;
        recv_idle = 0;
        set_axis(AXIS_X);
        queue_random(70);
        // sender pauses until every owed pair word is out
        wait_idle(0);
        queue_random(70);
        wait_idle(SETTLE_CYCLES);

        $display("%0d box words sent over sweep axes x, y, z and code three, %0d pair words checked",
                 boxes_sent, pairs_seen);
        $display("%0d boxes lost to a full active list, %0d mismatches, %0d pair words unclaimed",
                 boxes_lost, mismatches, pairs_due.size());
        if (mismatches == 0 && pairs_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
